// ===== src/bmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmmd_pkg: shared types and constants
// Region codes, controller kinds, internal store layout and the structs that
// travel between the decoder, the bank registers and the top level.
// ----------------------------------------------------------------------------
package bmmd_pkg;

  // Controller kind register codes; the unused code acts as no banking
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    REGION_ROM      = 4'd0,
    REGION_VRAM     = 4'd1,
    REGION_EXTRAM   = 4'd2,
    REGION_WORKRAM  = 4'd3,
    REGION_SPRITES  = 4'd4,
    REGION_HIGHRAM  = 4'd5,
    REGION_INT_EN   = 4'd6,
    REGION_IO       = 4'd7,
    REGION_UNUSABLE = 4'd8
  } region_e;

  // Bus command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Controller register select, address bits 14:13 of a ROM-area write
  localparam logic [1:0] SEL_RAM_EN   = 2'd0;
  localparam logic [1:0] SEL_ROM_LOW  = 2'd1;
  localparam logic [1:0] SEL_ROM_HIGH = 2'd2;
  localparam logic [1:0] SEL_MODE     = 2'd3;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  // Layout of the shared store; external RAM banks sit at the top
  localparam int WINDOW_BYTES = 8192;
  localparam int VRAM_BASE    = 0;
  localparam int WRAM_BASE    = 8192;
  localparam int OAM_BASE     = 16384;
  localparam int HRAM_BASE    = 16640;
  localparam int EXT_BASE     = 32768;

  localparam int ROM_BANK_W = 7;
  localparam int ROM_ADDR_W = 21;
  localparam int RAM_BANK_W = 2;

  // Bank register view used by the decoder
  typedef struct packed {
    logic [ROM_BANK_W-1:0] eff_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_enabled;
    logic [7:0]            int_enable;
  } ctrl_state_t;

  // Decoded access, store address travels separately
  typedef struct packed {
    region_e               region;
    logic                  mem_en;
    logic                  mem_we;
    logic                  use_mem;
    logic [7:0]            fixed_data;
    logic [ROM_ADDR_W-1:0] rom_address;
  } dec_t;

endpackage

// ===== src/banked_memory_map_decoder.sv =====
// ----------------------------------------------------------------------------
// banked_memory_map_decoder: 16-bit bus decoder with MBC1/MBC2 banking
// Decodes byte accesses into the memory map and keeps the cartridge bank
// registers and all internal RAMs.
// ----------------------------------------------------------------------------
// After reset the block zeroes its shared RAM one byte a cycle, over all
// 32768 + EXT_RAM_BANKS * 8192 bytes (65536 at the default); no item is
// taken during that sweep, but controller kind writes are. After that an item
// is taken every cycle unless a held result stalls it: it reads or writes the
// single-port RAM at the edge it is accepted, and its result shows in the
// output register in the following cycle. The next item can enter at the
// same edge that result is taken, so a stalled output holds the input side
// back. Bank register writes apply to the very next item.
module banked_memory_map_decoder #(
  parameter int EXT_RAM_BANKS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [3:0]  region_o,
  output logic [20:0] rom_address_o
);

  localparam int DEPTH = bmmd_pkg::EXT_BASE + EXT_RAM_BANKS * bmmd_pkg::WINDOW_BYTES;
  localparam int AW    = $clog2(DEPTH);

  bmmd_pkg::ctrl_state_t ctrl;
  bmmd_pkg::dec_t        dec;
  logic [AW-1:0]         mem_addr;
  logic [7:0]            mem_rdata;
  logic                  store_ready;
  logic                  accept;

  logic                  out_valid_q;
  logic [3:0]            region_q;
  logic [20:0]           rom_addr_q;
  logic                  use_mem_q;
  logic [7:0]            fixed_q;

  assign in_ready_o = store_ready && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  bmmd_bank_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .wr_en_i      (accept && (cmd_i == bmmd_pkg::CMD_WRITE)),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .ctrl_o       (ctrl)
  );

  bmmd_decode #(
    .AW            (AW),
    .EXT_RAM_BANKS (EXT_RAM_BANKS)
  ) u_dec (
    .cmd_i      (cmd_i),
    .address_i  (address_i),
    .ctrl_i     (ctrl),
    .dec_o      (dec),
    .mem_addr_o (mem_addr)
  );

  bmmd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept && dec.mem_en),
    .we_i    (dec.mem_we),
    .addr_i  (mem_addr),
    .wdata_i (write_data_i),
    .rdata_o (mem_rdata),
    .ready_o (store_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      region_q   <= 4'(dec.region);
      rom_addr_q <= dec.rom_address;
      use_mem_q  <= dec.use_mem;
      fixed_q    <= dec.fixed_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = use_mem_q ? mem_rdata : fixed_q;
  assign region_o      = region_q;
  assign rom_address_o = rom_addr_q;

endmodule

// ===== src/bmmd_bank_regs.sv =====
// ----------------------------------------------------------------------------
// bmmd_bank_regs: cartridge controller registers
// Controller kind, ROM and RAM bank, RAM enable, banking mode and interrupt
// enable; computes the effective ROM bank.
// ----------------------------------------------------------------------------
module bmmd_bank_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  logic                  wr_en_i,
  input  logic [15:0]           address_i,
  input  logic [7:0]            write_data_i,
  output bmmd_pkg::ctrl_state_t ctrl_o
);

  logic [1:0]                      kind_q;
  logic [bmmd_pkg::ROM_BANK_W-1:0] rom_bank_q, rom_bank_d;
  logic [bmmd_pkg::RAM_BANK_W-1:0] ram_bank_q, ram_bank_d;
  logic                            ram_en_q, ram_en_d;
  logic                            mode_q, mode_d;
  logic [7:0]                      ie_q, ie_d;
  logic [1:0]                      sel;
  logic                            key_ok;

  assign sel    = address_i[14:13];
  assign key_ok = (write_data_i[3:0] == bmmd_pkg::RAM_EN_KEY);

  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    ram_en_d   = ram_en_q;
    mode_d     = mode_q;
    ie_d       = ie_q;
    if (wr_en_i && !address_i[15]) begin
      unique case (kind_q)
        bmmd_pkg::KIND_MBC1: begin
          unique case (sel)
            bmmd_pkg::SEL_RAM_EN:  ram_en_d = key_ok;
            bmmd_pkg::SEL_ROM_LOW: rom_bank_d = {rom_bank_q[6:5], write_data_i[4:0]};
            bmmd_pkg::SEL_ROM_HIGH: begin
              if (mode_q) ram_bank_d = write_data_i[1:0];
              else        rom_bank_d = {write_data_i[1:0], rom_bank_q[4:0]};
            end
            default: mode_d = write_data_i[0];
          endcase
        end
        bmmd_pkg::KIND_MBC2: begin
          // RAM enable only decodes with address bit 8 low
          if (sel == bmmd_pkg::SEL_RAM_EN && !address_i[8]) ram_en_d = key_ok;
          if (sel == bmmd_pkg::SEL_ROM_LOW) rom_bank_d = {3'b000, write_data_i[3:0]};
        end
        default: ;
      endcase
    end
    if (wr_en_i && (address_i == 16'hFFFF)) ie_d = write_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= 2'd0;
      rom_bank_q <= '0;
      ram_bank_q <= '0;
      ram_en_q   <= 1'b0;
      mode_q     <= 1'b0;
      ie_q       <= '0;
    end else begin
      if (cfg_we_i) kind_q <= cfg_wdata_i;
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      ram_en_q   <= ram_en_d;
      mode_q     <= mode_d;
      ie_q       <= ie_d;
    end
  end

  // bank 0 in the low bits reads as bank 1
  always_comb begin
    ctrl_o.ram_bank    = ram_bank_q;
    ctrl_o.ram_enabled = ram_en_q;
    ctrl_o.int_enable  = ie_q;
    unique case (kind_q)
      bmmd_pkg::KIND_MBC1:
        ctrl_o.eff_bank = (rom_bank_q[4:0] == 5'd0) ? {rom_bank_q[6:5], 5'd1} : rom_bank_q;
      bmmd_pkg::KIND_MBC2:
        ctrl_o.eff_bank = (rom_bank_q[3:0] == 4'd0) ? 7'd1 : {3'b000, rom_bank_q[3:0]};
      default:
        ctrl_o.eff_bank = 7'd1;
    endcase
  end

endmodule

// ===== src/bmmd_decode.sv =====
// ----------------------------------------------------------------------------
// bmmd_decode: address map decoder
// Maps one bus access to its region, the shared store address, the fixed
// read byte and the physical ROM address.
// ----------------------------------------------------------------------------
module bmmd_decode #(
  parameter int AW            = 16,
  parameter int EXT_RAM_BANKS = 4
) (
  input  logic                  cmd_i,
  input  logic [15:0]           address_i,
  input  bmmd_pkg::ctrl_state_t ctrl_i,
  output bmmd_pkg::dec_t        dec_o,
  output logic [AW-1:0]         mem_addr_o
);

  logic [bmmd_pkg::RAM_BANK_W-1:0] ext_bank;
  logic                            rd;

  assign rd = (cmd_i == bmmd_pkg::CMD_READ);

  // bank number wrapped to the fitted banks; at most three subtract steps
  always_comb begin
    ext_bank = ctrl_i.ram_bank;
    for (int i = 0; i < 3; i++) begin
      if (int'(ext_bank) >= EXT_RAM_BANKS)
        ext_bank = ext_bank - bmmd_pkg::RAM_BANK_W'(EXT_RAM_BANKS);
    end
  end

  always_comb begin
    dec_o      = '0;
    mem_addr_o = '0;
    priority if (!address_i[15]) begin
      dec_o.region = bmmd_pkg::REGION_ROM;
      if (rd) begin
        dec_o.rom_address = address_i[14] ? {ctrl_i.eff_bank, address_i[13:0]}
                                          : {7'd0, address_i[13:0]};
      end
    end else if (address_i < 16'hA000) begin
      dec_o.region  = bmmd_pkg::REGION_VRAM;
      dec_o.mem_en  = 1'b1;
      dec_o.mem_we  = !rd;
      dec_o.use_mem = rd;
      mem_addr_o    = AW'(bmmd_pkg::VRAM_BASE) + AW'(address_i[12:0]);
    end else if (address_i < 16'hC000) begin
      dec_o.region = bmmd_pkg::REGION_EXTRAM;
      if (ctrl_i.ram_enabled) begin
        dec_o.mem_en  = 1'b1;
        dec_o.mem_we  = !rd;
        dec_o.use_mem = rd;
        mem_addr_o    = AW'(bmmd_pkg::EXT_BASE) + AW'({ext_bank, address_i[12:0]});
      end else if (rd) begin
        dec_o.fixed_data = 8'hFF;
      end
    end else if (address_i < 16'hFE00) begin
      // work RAM and its echo
      dec_o.region  = bmmd_pkg::REGION_WORKRAM;
      dec_o.mem_en  = 1'b1;
      dec_o.mem_we  = !rd;
      dec_o.use_mem = rd;
      mem_addr_o    = AW'(bmmd_pkg::WRAM_BASE) + AW'(address_i[12:0]);
    end else if (address_i < 16'hFEA0) begin
      dec_o.region  = bmmd_pkg::REGION_SPRITES;
      dec_o.mem_en  = 1'b1;
      dec_o.mem_we  = !rd;
      dec_o.use_mem = rd;
      mem_addr_o    = AW'(bmmd_pkg::OAM_BASE) + AW'(address_i[7:0]);
    end else if (address_i < 16'hFF00) begin
      dec_o.region = bmmd_pkg::REGION_UNUSABLE;
    end else if (address_i < 16'hFF80) begin
      dec_o.region = bmmd_pkg::REGION_IO;
    end else if (address_i != 16'hFFFF) begin
      dec_o.region  = bmmd_pkg::REGION_HIGHRAM;
      dec_o.mem_en  = 1'b1;
      dec_o.mem_we  = !rd;
      dec_o.use_mem = rd;
      mem_addr_o    = AW'(bmmd_pkg::HRAM_BASE) + AW'(address_i[6:0]);
    end else begin
      dec_o.region = bmmd_pkg::REGION_INT_EN;
      if (rd) dec_o.fixed_data = ctrl_i.int_enable;
    end
  end

endmodule

// ===== src/bmmd_store.sv =====
// ----------------------------------------------------------------------------
// bmmd_store: shared byte store
// One synchronous RAM holding video, work, sprite, high and external RAM,
// with a zeroing sweep after reset and a registered read port.
// ----------------------------------------------------------------------------
module bmmd_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o,
  output logic          ready_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] clr_addr_q;
  logic          clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

// ===== src/bmmd_checker.sv =====
// ----------------------------------------------------------------------------
// bmmd_checker: port-level checks
// Watches the top level's ports for result timing and decode invariants.
// ----------------------------------------------------------------------------
module bmmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        cmd_i,
  input logic [15:0] address_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_data_o,
  input logic [3:0]  region_o,
  input logic [20:0] rom_address_o
);

  logic acc_rd;
  logic acc_wr;

  assign acc_rd = in_valid_i && in_ready_o && (cmd_i == bmmd_pkg::CMD_READ);
  assign acc_wr = in_valid_i && in_ready_o && (cmd_i == bmmd_pkg::CMD_WRITE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(region_o) && $stable(rom_address_o))
    else $error("stalled result changed");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_wr |=> out_valid_o && read_data_o == 8'h00 && rom_address_o == 21'd0)
    else $error("write result not zero");

  a_rom_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_rd && address_i[15:14] == 2'b00 |=> out_valid_o
      && region_o == 4'(bmmd_pkg::REGION_ROM)
      && rom_address_o[13:0] == $past(address_i[13:0]) && rom_address_o[20:14] == 7'd0)
    else $error("fixed ROM bank address wrong");

  a_rom_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_rd && address_i[15:14] == 2'b01 |=> rom_address_o[20:14] != 7'd0
      && rom_address_o[13:0] == $past(address_i[13:0]))
    else $error("switchable ROM bank reads as bank zero");

  a_int_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && address_i == 16'hFFFF |=>
      region_o == 4'(bmmd_pkg::REGION_INT_EN))
    else $error("interrupt enable misdecoded");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .cmd_i         (cmd_i),
  .address_i     (address_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .read_data_o   (read_data_o),
  .region_o      (region_o),
  .rom_address_o (rom_address_o)
);

// ===== sim/banked_memory_map_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_tb: self-checking bench for the bus decoder
// Drives byte reads and writes over the whole 16-bit map under every
// controller kind. A short directed table covers the map edges, bank
// register corners and disabled external RAM. Random accesses follow, with
// random stalls on both channels. Every result is checked against its typed row
// or a behavioral model of the map, the bank registers and all internal RAMs.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder_tb;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam int         ITEMS_PER_KIND = 150;
  localparam int         WATCHDOG_LIMIT = 400000;
  localparam int         LONG_HOLD      = 300;

  localparam logic RD = bmmd_pkg::CMD_READ;
  localparam logic WR = bmmd_pkg::CMD_WRITE;

  typedef struct packed {
    logic [7:0]        data;
    bmmd_pkg::region_e region;
    logic [20:0]       rom;
  } bus_result_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        typed;
    bus_result_t result;
  } probe_t;

  localparam logic TYPED = 1'b1;
  localparam logic MODEL = 1'b0;

  // Run under MBC1; typed rows are read straight off the map rules
  localparam int NUM_PROBES = 28;
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{RD, 16'h3FFF, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h003FFF}},
    '{RD, 16'h4000, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h004000}},
    '{RD, 16'h7FFF, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h007FFF}},
    '{RD, 16'h8000, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_VRAM, 21'h0}},
    '{RD, 16'hA000, 8'h00, TYPED, '{8'hFF, bmmd_pkg::REGION_EXTRAM, 21'h0}},
    '{RD, 16'hFFFF, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_INT_EN, 21'h0}},
    '{WR, 16'h0000, 8'h1A, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{WR, 16'hA000, 8'h5C, TYPED, '{8'h00, bmmd_pkg::REGION_EXTRAM, 21'h0}},
    '{RD, 16'hA000, 8'h00, MODEL, '0},
    '{WR, 16'h4000, 8'h03, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{WR, 16'h2000, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{RD, 16'h4000, 8'h00, MODEL, '0},
    '{WR, 16'h2000, 8'hFF, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{RD, 16'h7FFF, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h1FFFFF}},
    '{WR, 16'h6000, 8'h01, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{WR, 16'h4000, 8'h02, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{WR, 16'hBFFF, 8'hFF, TYPED, '{8'h00, bmmd_pkg::REGION_EXTRAM, 21'h0}},
    '{RD, 16'hBFFF, 8'h00, MODEL, '0},
    '{WR, 16'h0100, 8'h0B, TYPED, '{8'h00, bmmd_pkg::REGION_ROM, 21'h0}},
    '{RD, 16'hBFFF, 8'h00, TYPED, '{8'hFF, bmmd_pkg::REGION_EXTRAM, 21'h0}},
    '{WR, 16'hE000, 8'hA5, TYPED, '{8'h00, bmmd_pkg::REGION_WORKRAM, 21'h0}},
    '{RD, 16'hC000, 8'h00, MODEL, '0},
    '{WR, 16'hFE9F, 8'h77, TYPED, '{8'h00, bmmd_pkg::REGION_SPRITES, 21'h0}},
    '{RD, 16'hFE9F, 8'h00, MODEL, '0},
    '{RD, 16'hFEA0, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_UNUSABLE, 21'h0}},
    '{RD, 16'hFF00, 8'h00, TYPED, '{8'h00, bmmd_pkg::REGION_IO, 21'h0}},
    '{WR, 16'hFFFE, 8'h33, TYPED, '{8'h00, bmmd_pkg::REGION_HIGHRAM, 21'h0}},
    '{RD, 16'hFFFE, 8'h00, MODEL, '0}
  };

  localparam logic [1:0] PHASE_KIND [6] = '{bmmd_pkg::KIND_MBC1, bmmd_pkg::KIND_MBC2,
                                            bmmd_pkg::KIND_NONE, KIND_UNUSED,
                                            bmmd_pkg::KIND_MBC1, bmmd_pkg::KIND_MBC2};

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready_o;
  logic        cmd       = bmmd_pkg::CMD_READ;
  logic [15:0] address   = '0;
  logic [7:0]  wdata     = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b1;
  logic [7:0]  read_data_o;
  logic [3:0]  region_o;
  logic [20:0] rom_address_o;

  // Typed expectation riding along with the current item
  logic        use_typed    = 1'b0;
  bus_result_t typed_result = '0;

  // Model state
  logic [7:0] vram_mem [8192];
  logic [7:0] ext_mem  [32768];
  logic [7:0] wram_mem [8192];
  logic [7:0] oam_mem  [160];
  logic [7:0] hram_mem [127];
  logic [7:0] ie_reg;
  logic [6:0] rom_bank_reg;
  logic [1:0] ram_bank_reg;
  logic       ram_on;
  logic       bank_mode_reg;
  logic [1:0] kind_reg;

  bus_result_t pending_results [$];
  int          mismatches    = 0;
  int          items_taken   = 0;
  int          results_taken = 0;
  int          writes_taken  = 0;
  int          idle_cycles   = 0;
  int          region_seen [9];
  logic        no_idle       = 1'b0;

  banked_memory_map_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd),
    .address_i    (address),
    .write_data_i (wdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data_o),
    .region_o     (region_o),
    .rom_address_o(rom_address_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < 8192; i++) begin
      vram_mem[i] = '0;
      wram_mem[i] = '0;
    end
    for (int i = 0; i < 32768; i++) ext_mem[i] = '0;
    for (int i = 0; i < 160; i++) oam_mem[i] = '0;
    for (int i = 0; i < 127; i++) hram_mem[i] = '0;
    for (int i = 0; i < 9; i++) region_seen[i] = 0;
    ie_reg        = '0;
    rom_bank_reg  = '0;
    ram_bank_reg  = '0;
    ram_on        = 1'b0;
    bank_mode_reg = 1'b0;
    kind_reg      = bmmd_pkg::KIND_NONE;
  end

  function automatic logic [6:0] rom_bank_in_use();
    logic [6:0] b;
    if (kind_reg == bmmd_pkg::KIND_MBC1) begin
      b = rom_bank_reg;
      if (b[4:0] == 5'd0) b[0] = 1'b1;
    end else if (kind_reg == bmmd_pkg::KIND_MBC2) begin
      b = {3'd0, rom_bank_reg[3:0]};
      if (b == 7'd0) b = 7'd1;
    end else begin
      b = 7'd1;
    end
    return b;
  endfunction

  // Applies one access to the model and returns what the bus should show
  function automatic bus_result_t access_memory_map(input logic wr, input logic [15:0] a,
                                                    input logic [7:0] d);
    bus_result_t r;
    logic [14:0] ext_at;
    r      = '0;
    ext_at = {ram_bank_reg, a[12:0]};
    if (a < 16'h8000) begin
      r.region = bmmd_pkg::REGION_ROM;
      if (wr) begin
        if (kind_reg == bmmd_pkg::KIND_MBC1) begin
          unique case (a[14:13])
            bmmd_pkg::SEL_RAM_EN:  ram_on = (d[3:0] == bmmd_pkg::RAM_EN_KEY);
            bmmd_pkg::SEL_ROM_LOW: rom_bank_reg[4:0] = d[4:0];
            bmmd_pkg::SEL_ROM_HIGH: begin
              if (bank_mode_reg) ram_bank_reg = d[1:0];
              else rom_bank_reg[6:5] = d[1:0];
            end
            default:     bank_mode_reg = d[0];
          endcase
        end else if (kind_reg == bmmd_pkg::KIND_MBC2) begin
          // MBC2 only honors the enable key with address bit 8 clear
          if (a[14:13] == bmmd_pkg::SEL_RAM_EN && !a[8])
            ram_on = (d[3:0] == bmmd_pkg::RAM_EN_KEY);
          else if (a[14:13] == bmmd_pkg::SEL_ROM_LOW) rom_bank_reg = {3'd0, d[3:0]};
        end
      end else if (a < 16'h4000) begin
        r.rom = {5'd0, a};
      end else begin
        r.rom = {rom_bank_in_use(), a[13:0]};
      end
    end else if (a < 16'hA000) begin
      r.region = bmmd_pkg::REGION_VRAM;
      if (wr) vram_mem[a[12:0]] = d;
      else r.data = vram_mem[a[12:0]];
    end else if (a < 16'hC000) begin
      r.region = bmmd_pkg::REGION_EXTRAM;
      if (wr) begin
        if (ram_on) ext_mem[ext_at] = d;
      end else begin
        r.data = ram_on ? ext_mem[ext_at] : 8'hFF;
      end
    end else if (a < 16'hFE00) begin
      r.region = bmmd_pkg::REGION_WORKRAM;
      if (wr) wram_mem[a[12:0]] = d;
      else r.data = wram_mem[a[12:0]];
    end else if (a < 16'hFEA0) begin
      r.region = bmmd_pkg::REGION_SPRITES;
      if (wr) oam_mem[a - 16'hFE00] = d;
      else r.data = oam_mem[a - 16'hFE00];
    end else if (a < 16'hFF00) begin
      r.region = bmmd_pkg::REGION_UNUSABLE;
    end else if (a < 16'hFF80) begin
      r.region = bmmd_pkg::REGION_IO;
    end else if (a < 16'hFFFF) begin
      r.region = bmmd_pkg::REGION_HIGHRAM;
      if (wr) hram_mem[a - 16'hFF80] = d;
      else r.data = hram_mem[a - 16'hFF80];
    end else begin
      r.region = bmmd_pkg::REGION_INT_EN;
      if (wr) ie_reg = d;
      else r.data = ie_reg;
    end
    return r;
  endfunction

  // Output check first, then the item entering at the same edge
  always @(posedge clk_i) begin
    bus_result_t want;
    bus_result_t model;
    if (out_valid_o && out_ready) begin
      results_taken++;
      if (region_o < 4'd9) region_seen[region_o]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: data %h region %0d rom %h",
                 $time, read_data_o, region_o, rom_address_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.data) begin
          $display("%0t: read_data expected %h got %h", $time, want.data, read_data_o);
          mismatches++;
        end
        if (region_o !== want.region) begin
          $display("%0t: region expected %0d got %0d", $time, want.region, region_o);
          mismatches++;
        end
        if (rom_address_o !== want.rom) begin
          $display("%0t: rom_address expected %h got %h", $time, want.rom, rom_address_o);
          mismatches++;
        end
      end
    end
    if (in_valid && in_ready_o) begin
      items_taken++;
      if (cmd == bmmd_pkg::CMD_WRITE) writes_taken++;
      model = access_memory_map(cmd, address, wdata);
      pending_results.push_back(use_typed ? typed_result : model);
    end
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("banked_memory_map_decoder_tb: errors");
    $finish;
  end

  // Receiver: short random stalls, one long hold-off to back up the input
  initial begin
    int stall_left;
    int roll;
    logic held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_taken >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_ready <= 1'b1;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 15) stall_left = $urandom_range(1, 3);
        else if (roll < 18) stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high
  task automatic offer_item(input logic c, input logic [15:0] a, input logic [7:0] d,
                            input logic typed, input bus_result_t r);
    int gap;
    int roll;
    gap  = 0;
    roll = $urandom_range(0, 99);
    if (!no_idle) begin
      if (roll < 20) gap = $urandom_range(1, 3);
      else if (roll < 23) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    address      <= a;
    wdata        <= d;
    use_typed    <= typed;
    typed_result <= r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_kind(input logic [1:0] k);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    kind_reg  = k;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int          pick;
    int          lo;
    int          span;
    int          off;
    logic        c;
    logic [15:0] a;
    logic [7:0]  d;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Kind may be written while the RAM clear runs
    set_kind(bmmd_pkg::KIND_MBC1);
    for (int i = 0; i < NUM_PROBES; i++)
      offer_item(PROBES[i].cmd, PROBES[i].addr, PROBES[i].wdata, PROBES[i].typed,
                 PROBES[i].result);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      set_kind(PHASE_KIND[p]);
      no_idle = (p == 3);
      for (int i = 0; i < ITEMS_PER_KIND; i++) begin
        if (p == 1 && i == ITEMS_PER_KIND / 2) drain_results();
        pick = $urandom_range(0, 99);
        c    = 1'($urandom_range(0, 1));
        d    = 8'($urandom_range(0, 255));
        if (pick < 20) begin
          // bank register writes, half of them carrying the enable key
          c = bmmd_pkg::CMD_WRITE;
          a = 16'($urandom_range(0, 'h7FFF));
          if ($urandom_range(0, 1)) d[3:0] = bmmd_pkg::RAM_EN_KEY;
        end else if (pick < 32) begin
          c = bmmd_pkg::CMD_READ;
          a = 16'($urandom_range(0, 'h7FFF));
        end else begin
          if (pick < 42)      begin lo = 'h8000; span = 'h1FFF; end
          else if (pick < 57) begin lo = 'hA000; span = 'h1FFF; end
          else if (pick < 68) begin lo = 'hC000; span = 'h3DFF; end
          else if (pick < 76) begin lo = 'hFE00; span = 'h009F; end
          else if (pick < 80) begin lo = 'hFEA0; span = 'h005F; end
          else if (pick < 85) begin lo = 'hFF00; span = 'h007F; end
          else if (pick < 93) begin lo = 'hFF80; span = 'h007E; end
          else                begin lo = 'hFFFF; span = 0;      end
          // half the accesses hit a few low entries so reads find earlier writes
          if ($urandom_range(0, 1)) off = $urandom_range(0, span);
          else off = $urandom_range(0, (span < 7) ? span : 7);
          a = 16'(lo + off);
        end
        offer_item(c, a, d, MODEL, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches++;
    end

    $display("Run: %0d items (%0d writes), %0d results, kinds none/MBC1/MBC2/unused.",
             items_taken, writes_taken, results_taken);
    $display({"Per region: rom %0d vram %0d ext %0d wram %0d oam %0d hram %0d",
              " ie %0d io %0d unus %0d"},
             region_seen[0], region_seen[1], region_seen[2], region_seen[3], region_seen[4],
             region_seen[5], region_seen[6], region_seen[7], region_seen[8]);
    if (mismatches == 0) begin
      $display("banked_memory_map_decoder_tb: clean");
    end else begin
      $display("banked_memory_map_decoder_tb: errors");
    end
    $finish;
  end

endmodule
